// ===== rtl/core/dtq_pkg.sv =====
// dtq_pkg: shared types, codes and helpers of the deadline timer queue
// no dependencies; used by the interfaces, controller, datapath and top level
package dtq_pkg;

	localparam logic [2:0] KIND_INIT     = 3'd0;
	localparam logic [2:0] KIND_SHUTDOWN = 3'd1;
	localparam logic [2:0] KIND_INSERT   = 3'd2;
	localparam logic [2:0] KIND_REMOVE   = 3'd3;
	localparam logic [2:0] KIND_PRIME    = 3'd4;
	localparam logic [2:0] KIND_CANCEL   = 3'd5;
	localparam logic [2:0] KIND_EXPIRE   = 3'd6;
	localparam logic [2:0] KIND_QUERY    = 3'd7;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NOT_ACTIVE = 2'd1;
	localparam logic [1:0] ST_PARAM_ERR  = 2'd2;
	localparam logic [1:0] ST_FULL       = 2'd3;

	localparam int MAX_RES = 48;
	localparam int RES_W   = 6;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] task_handle;
		logic [31:0] delay_us;
		logic        periodic;
		logic [63:0] now_us;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        fired;
		logic [15:0] fired_handle;
		logic [31:0] fired_generation;
		logic        rearm;
		logic [63:0] rearm_deadline;
		logic [31:0] generation;
		logic [3:0]  active_count;
		logic        last;
	} result_t;

	typedef struct packed {
		logic       load;
		logic       init;
		logic       shut;
		logic       insert;
		logic       latch_slot;
		logic       rm_start;
		logic       sift;
		logic       prime_set;
		logic       push;
		logic       gen_inc;
		logic       free_h;
		logic       pop;
		logic       rep_a;
		logic       rep_b;
		logic       exp_clr;
		logic       buf_rd;
		logic       res_load;
		logic       res_fire;
		logic [1:0] res_status;
		logic       res_rearm;
		logic       res_gen;
		logic       res_zero_rd;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       running;
		logic       h_zero;
		logic       found;
		logic       found_sched;
		logic       free_ok;
		logic       sift_done;
		logic       exp_due;
		logic       per_nz;
		logic       exp_any;
		logic       emit_last;
		logic       out_free;
	} stat_t;

	// wrap-safe ordering: a later than b when a - b is positive
	function automatic logic later(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] d;
		d = a - b;
		return (d != 64'd0) && !d[63];
	endfunction

endpackage

// ===== rtl/core/dtq_if.sv =====
// dtq_req_if / dtq_rsp_if: valid-ready channels of the timer queue
// depends on dtq_pkg for the word types
interface dtq_req_if;
	logic           valid;
	logic           ready;
	dtq_pkg::item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface dtq_rsp_if;
	logic             valid;
	logic             ready;
	dtq_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/dtq_ctrl.sv =====
// dtq_ctrl: sequencer of the timer queue, issues datapath commands
// depends on dtq_pkg (cmd_t, stat_t, codes)
module dtq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  dtq_pkg::stat_t  stat,
	output dtq_pkg::cmd_t   cmd
);
	import dtq_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE      = 14'b00000000000001,
		S_EXEC      = 14'b00000000000010,
		S_RM        = 14'b00000000000100,
		S_SIFT      = 14'b00000000001000,
		S_PR_SET    = 14'b00000000010000,
		S_PUSH      = 14'b00000000100000,
		S_FIN_RM    = 14'b00000001000000,
		S_FIN_CN    = 14'b00000010000000,
		S_EXP_CHK   = 14'b00000100000000,
		S_EXP_PER   = 14'b00001000000000,
		S_EXP_CATCH = 14'b00010000000000,
		S_RESULT    = 14'b00100000000000,
		S_EMIT_RD   = 14'b01000000000000,
		S_EMIT_LD   = 14'b10000000000000
	} state_t;

	state_t     state_q, state_d, ret_q, ret_d;
	logic [1:0] status_q, status_d;
	logic       rearm_q, rearm_d, gen_q, gen_d, zrd_q, zrd_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		ret_d    = ret_q;
		status_d = status_q;
		rearm_d  = rearm_q;
		gen_d    = gen_q;
		zrd_d    = zrd_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				status_d = ST_OK;
				rearm_d  = 1'b0;
				gen_d    = 1'b0;
				zrd_d    = 1'b0;
				state_d  = S_RESULT;
				case (stat.kind)
					KIND_INIT: cmd.init = 1'b1;
					KIND_SHUTDOWN: begin
						cmd.shut = 1'b1;
						rearm_d  = 1'b1;
						zrd_d    = 1'b1;
					end
					KIND_QUERY: begin
						if (stat.h_zero) status_d = ST_PARAM_ERR;
						else gen_d = 1'b1;
					end
					KIND_EXPIRE: begin
						cmd.exp_clr = 1'b1;
						state_d     = S_EXP_CHK;
					end
					default: begin
						if (!stat.running) begin
							status_d = ST_NOT_ACTIVE;
						end else if (stat.h_zero) begin
							status_d = ST_PARAM_ERR;
						end else if (stat.kind == KIND_INSERT) begin
							if (stat.free_ok) cmd.insert = 1'b1;
							else status_d = ST_FULL;
						end else if (stat.kind == KIND_REMOVE) begin
							if (stat.found) begin
								cmd.latch_slot = 1'b1;
								rearm_d        = stat.found_sched;
								ret_d          = S_FIN_RM;
								state_d        = S_RM;
							end else status_d = ST_NOT_ACTIVE;
						end else if (stat.kind == KIND_PRIME) begin
							if (stat.found) begin
								cmd.latch_slot = 1'b1;
								rearm_d        = 1'b1;
								ret_d          = S_PR_SET;
								state_d        = S_RM;
							end else status_d = ST_NOT_ACTIVE;
						end else begin
							if (stat.found && stat.found_sched) begin
								cmd.latch_slot = 1'b1;
								rearm_d        = 1'b1;
								ret_d          = S_FIN_CN;
								state_d        = S_RM;
							end else status_d = ST_NOT_ACTIVE;
						end
					end
				endcase
			end
			S_RM: begin
				cmd.rm_start = 1'b1;
				state_d      = S_SIFT;
			end
			S_SIFT: begin
				if (stat.sift_done) state_d = ret_q;
				else cmd.sift = 1'b1;
			end
			S_PR_SET: begin
				cmd.prime_set = 1'b1;
				ret_d         = S_RESULT;
				state_d       = S_PUSH;
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_SIFT;
			end
			S_FIN_RM: begin
				cmd.free_h  = 1'b1;
				cmd.gen_inc = 1'b1;
				state_d     = S_RESULT;
			end
			S_FIN_CN: begin
				cmd.gen_inc = 1'b1;
				state_d     = S_RESULT;
			end
			S_EXP_CHK: begin
				if (stat.exp_due) begin
					cmd.pop = 1'b1;
					ret_d   = S_EXP_PER;
					state_d = S_SIFT;
				end else if (stat.exp_any) begin
					state_d = S_EMIT_RD;
				end else begin
					status_d = ST_OK;
					rearm_d  = 1'b1;
					state_d  = S_RESULT;
				end
			end
			S_EXP_PER: begin
				if (stat.per_nz) begin
					cmd.rep_a = 1'b1;
					state_d   = S_EXP_CATCH;
				end else state_d = S_EXP_CHK;
			end
			S_EXP_CATCH: begin
				cmd.rep_b = 1'b1;
				ret_d     = S_EXP_CHK;
				state_d   = S_PUSH;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.res_load    = 1'b1;
					cmd.res_status  = status_q;
					cmd.res_rearm   = rearm_q;
					cmd.res_gen     = gen_q;
					cmd.res_zero_rd = zrd_q;
					state_d         = S_IDLE;
				end
			end
			S_EMIT_RD: begin
				cmd.buf_rd = 1'b1;
				state_d    = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				if (stat.out_free) begin
					cmd.res_load   = 1'b1;
					cmd.res_fire   = 1'b1;
					cmd.res_status = ST_OK;
					cmd.res_rearm  = 1'b1;
					state_d        = stat.emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			status_q <= ST_OK;
			rearm_q  <= 1'b0;
			gen_q    <= 1'b0;
			zrd_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			status_q <= status_d;
			rearm_q  <= rearm_d;
			gen_q    <= gen_d;
			zrd_q    <= zrd_d;
		end
	end

endmodule

// ===== rtl/core/dtq_dp.sv =====
// dtq_dp: task table, deadline heap, fired-word buffer and result register
// depends on dtq_pkg; driven by dtq_ctrl commands
module dtq_dp #(
	parameter int NUM_TASKS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dtq_pkg::item_t   req_data,
	input  logic             rsp_ready,
	output logic             rsp_valid,
	output dtq_pkg::result_t rsp_data,
	input  dtq_pkg::cmd_t    cmd,
	output dtq_pkg::stat_t   stat
);
	import dtq_pkg::*;

	localparam int SW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int CW = $clog2(NUM_TASKS + 1);
	localparam int IW = SW + 2;

	item_t          item_q;
	logic           running_q;
	logic [31:0]    next_gen_q;
	logic [15:0]    handle_q [NUM_TASKS];
	logic           sched_q  [NUM_TASKS];
	logic [63:0]    dl_q     [NUM_TASKS];
	logic [31:0]    per_q    [NUM_TASKS];
	logic [31:0]    gen_q    [NUM_TASKS];
	logic [SW-1:0]  pos_q    [NUM_TASKS];
	logic [SW-1:0]  order_q  [NUM_TASKS];
	logic [CW-1:0]  cnt_q;
	logic [SW-1:0]  slot_q, idx_q;
	logic           up_q;
	logic [RES_W-1:0] n_q, k_q;
	logic [47:0]    fire_mem [MAX_RES];
	logic [47:0]    fire_q;
	result_t        out_q;
	logic           out_valid_q;

	// handle lookup, lowest slot wins
	logic          found, free_ok;
	logic [SW-1:0] fslot, free_slot;
	always_comb begin
		found     = 1'b0;
		fslot     = '0;
		free_ok   = 1'b0;
		free_slot = '0;
		for (int t = NUM_TASKS - 1; t >= 0; t--) begin
			if (handle_q[t] == item_q.task_handle) begin
				found = 1'b1;
				fslot = SW'(t);
			end
			if (handle_q[t] == 16'd0) begin
				free_ok   = 1'b1;
				free_slot = SW'(t);
			end
		end
	end

	logic [63:0] top_dl;
	assign top_dl = (cnt_q != '0) ? dl_q[order_q[0]] : 64'd0;

	// one sift step
	logic [SW-1:0] par, li, ri, sel, tgt;
	logic [IW-1:0] l_ext, r_ext;
	logic          has_l, has_r, up_swap, sift_done;
	always_comb begin
		par     = SW'((idx_q - 1'b1) >> 1);
		up_swap = (idx_q != '0) && later(dl_q[order_q[par]], dl_q[order_q[idx_q]]);
		l_ext   = IW'({idx_q, 1'b1});
		r_ext   = l_ext + 1'b1;
		has_l   = l_ext < IW'(cnt_q);
		has_r   = r_ext < IW'(cnt_q);
		li      = l_ext[SW-1:0];
		ri      = r_ext[SW-1:0];
		sel     = idx_q;
		if (has_l && later(dl_q[order_q[sel]], dl_q[order_q[li]])) sel = li;
		if (has_r && later(dl_q[order_q[sel]], dl_q[order_q[ri]])) sel = ri;
		sift_done = up_q ? !up_swap : (sel == idx_q);
		tgt       = up_q ? par : sel;
	end

	// removal of slot_q and pop of the top
	logic [CW-1:0] cnt_dec;
	logic [SW-1:0] rm_pos, rm_par, last_slot, top_slot;
	logic          rm_move, rm_up;
	always_comb begin
		cnt_dec   = cnt_q - 1'b1;
		rm_pos    = pos_q[slot_q];
		rm_par    = SW'((rm_pos - 1'b1) >> 1);
		last_slot = order_q[cnt_dec[SW-1:0]];
		top_slot  = order_q[0];
		rm_move   = sched_q[slot_q] && (cnt_dec != '0) && (IW'(rm_pos) < IW'(cnt_dec));
		rm_up     = rm_move && (rm_pos != '0)
			&& later(dl_q[order_q[rm_par]], dl_q[last_slot]);
	end

	// catch-up bound for periodic tasks, 4 * period at 34 bits
	logic [63:0] behind, lim;
	assign behind = item_q.now_us - dl_q[slot_q];
	assign lim    = {30'd0, per_q[slot_q], 2'b00};

	always_comb begin
		stat.kind        = item_q.kind;
		stat.running     = running_q;
		stat.h_zero      = (item_q.task_handle == 16'd0);
		stat.found       = found;
		stat.found_sched = sched_q[fslot];
		stat.free_ok     = free_ok;
		stat.sift_done   = sift_done;
		stat.exp_due     = (cnt_q != '0) && (n_q < RES_W'(MAX_RES))
			&& !later(dl_q[top_slot], item_q.now_us);
		stat.per_nz      = (per_q[slot_q] != 32'd0);
		stat.exp_any     = (n_q != '0);
		stat.emit_last   = (k_q == n_q - 1'b1);
		stat.out_free    = !out_valid_q || rsp_ready;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			next_gen_q <= 32'd1;
			cnt_q      <= '0;
			n_q        <= '0;
			k_q        <= '0;
			up_q       <= 1'b0;
			for (int t = 0; t < NUM_TASKS; t++) begin
				handle_q[t] <= 16'd0;
				sched_q[t]  <= 1'b0;
			end
		end else begin
			if (cmd.init) begin
				running_q  <= 1'b1;
				next_gen_q <= 32'd1;
				cnt_q      <= '0;
				for (int t = 0; t < NUM_TASKS; t++) begin
					handle_q[t] <= 16'd0;
					sched_q[t]  <= 1'b0;
				end
			end
			if (cmd.shut) running_q <= 1'b0;
			if (cmd.insert) begin
				handle_q[free_slot] <= item_q.task_handle;
				sched_q[free_slot]  <= 1'b0;
				next_gen_q          <= next_gen_q + 1'b1;
			end
			if (cmd.free_h) handle_q[slot_q] <= 16'd0;
			if (cmd.rm_start) begin
				up_q <= rm_up;
				if (sched_q[slot_q]) begin
					sched_q[slot_q] <= 1'b0;
					cnt_q           <= cnt_dec;
				end
			end
			if (cmd.pop) begin
				up_q              <= 1'b0;
				sched_q[top_slot] <= 1'b0;
				cnt_q             <= cnt_dec;
				n_q               <= n_q + 1'b1;
			end
			if (cmd.push && (cnt_q < CW'(NUM_TASKS))) begin
				up_q            <= 1'b1;
				sched_q[slot_q] <= 1'b1;
				cnt_q           <= cnt_q + 1'b1;
			end
			if (cmd.exp_clr) begin
				n_q <= '0;
				k_q <= '0;
			end
			if (cmd.res_load && cmd.res_fire) k_q <= k_q + 1'b1;
		end
	end

	// heap order, positions and cursors
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= req_data;
		if (cmd.latch_slot) slot_q <= fslot;
		if (cmd.rm_start) begin
			idx_q <= sched_q[slot_q] ? rm_pos : {SW{1'b1}};
			if (rm_move) begin
				order_q[rm_pos]  <= last_slot;
				pos_q[last_slot] <= rm_pos;
			end
		end
		if (cmd.pop) begin
			slot_q <= top_slot;
			idx_q  <= '0;
			if (cnt_dec != '0) begin
				order_q[0]       <= last_slot;
				pos_q[last_slot] <= '0;
			end
		end
		if (cmd.push && (cnt_q < CW'(NUM_TASKS))) begin
			order_q[cnt_q[SW-1:0]] <= slot_q;
			pos_q[slot_q]          <= cnt_q[SW-1:0];
			idx_q                  <= cnt_q[SW-1:0];
		end
		if (cmd.sift) begin
			order_q[idx_q]          <= order_q[tgt];
			order_q[tgt]            <= order_q[idx_q];
			pos_q[order_q[tgt]]     <= idx_q;
			pos_q[order_q[idx_q]]   <= tgt;
			idx_q                   <= tgt;
		end
	end

	// task payload
	always_ff @(posedge clk) begin
		if (cmd.insert) gen_q[free_slot] <= next_gen_q;
		if (cmd.gen_inc) gen_q[slot_q] <= gen_q[slot_q] + 1'b1;
		if (cmd.prime_set) begin
			dl_q[slot_q]  <= item_q.now_us + {32'd0, item_q.delay_us};
			per_q[slot_q] <= item_q.periodic ? item_q.delay_us : 32'd0;
			gen_q[slot_q] <= gen_q[slot_q] + 1'b1;
		end
		if (cmd.rep_a) begin
			dl_q[slot_q]  <= dl_q[slot_q] + {32'd0, per_q[slot_q]};
			gen_q[slot_q] <= gen_q[slot_q] + 1'b1;
		end
		if (cmd.rep_b && !behind[63] && (behind > lim))
			dl_q[slot_q] <= item_q.now_us + {32'd0, per_q[slot_q]};
	end

	// fired words
	always_ff @(posedge clk) begin
		if (cmd.pop) fire_mem[n_q] <= {handle_q[top_slot], gen_q[top_slot]};
		if (cmd.buf_rd) fire_q <= fire_mem[k_q];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.res_load) out_valid_q <= 1'b1;
		else if (rsp_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_q.status           <= cmd.res_status;
			out_q.fired            <= cmd.res_fire;
			out_q.fired_handle     <= cmd.res_fire ? fire_q[47:32] : 16'd0;
			out_q.fired_generation <= cmd.res_fire ? fire_q[31:0] : 32'd0;
			out_q.rearm            <= cmd.res_rearm;
			out_q.rearm_deadline   <= cmd.res_zero_rd ? 64'd0 : top_dl;
			out_q.generation       <= (cmd.res_gen && found) ? gen_q[fslot] : 32'd0;
			out_q.active_count     <= 4'(cnt_q);
			out_q.last             <= cmd.res_fire ? (k_q == n_q - 1'b1) : 1'b1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule

// ===== rtl/core/deadline_timer_queue_top.sv =====
// deadline_timer_queue_top: timer task table with a min-heap of deadlines
// depends on dtq_pkg, dtq_if, dtq_ctrl and dtq_dp
//
// usage
//   req carries one command word (kind, task_handle, delay_us, periodic,
//   now_us); rsp carries result words, the final one of a command with last
//   set. both are valid/ready channels, a word moves when both are high.
//   one command is worked on at a time: req.ready is high only while the
//   sequencer is idle, so the next command is taken as soon as the previous
//   one has loaded its final word into the result register, even while
//   that word still waits on rsp.
//   simple commands load the result register straight away; remove, prime
//   and cancel first take the task out of the heap by a sift walk, and prime
//   then pushes it back with a second walk. expire pops each due task and
//   sifts the heap, pushing a periodic task back with its next deadline,
//   then sends the result words one by one from the fired-word buffer. the
//   sift walk does one parent/child swap per cycle.
//   reset: table empty, queue empty, generation counter at one, not running;
//   no clearing pass is needed.
//   a stalled receiver holds the result register; the sequencer waits before
//   loading the next word, nothing is dropped.
module deadline_timer_queue_top #(
	parameter int NUM_TASKS = 8
) (
	input logic       clk,
	input logic       arst_n,
	dtq_req_if.sink   req,
	dtq_rsp_if.source rsp
);
	import dtq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer: decodes the command word and steps the heap operations
	dtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: table, heap, fired buffer and result register
	dtq_dp #(
		.NUM_TASKS (NUM_TASKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_data  (rsp.data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== dv/deadline_timer_queue_top_test.sv =====
// deadline_timer_queue_top_test: self-checking bench for the deadline timer queue
// depends on dtq_pkg, dtq_if and deadline_timer_queue_top
// a heap predictor computes expected result words; a monitor compares them field by field
`timescale 1ns / 100ps

module deadline_timer_queue_top_test;
	import dtq_pkg::*;

	localparam int NT = 8;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;

	dtq_req_if req();
	dtq_rsp_if rsp();

	deadline_timer_queue_top #(.NUM_TASKS(NT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state, a shadow of the task table and the heap
	logic [15:0] tbl_handle [NT];
	logic [63:0] tbl_deadline [NT];
	logic [31:0] tbl_period [NT];
	logic [31:0] tbl_gen [NT];
	logic        tbl_sched [NT];
	int          tbl_pos [NT];
	int          heap_slot [NT];
	int          heap_n;
	logic [31:0] gen_counter;
	logic        is_running;

	item_t   pending_words[$];
	result_t expected_words[$];
	int      fail_count;
	logic    drain_hold;

	function automatic logic is_later(logic [63:0] a, logic [63:0] b);
		logic [63:0] d;
		d = a - b;
		return (d != 64'd0) && !d[63];
	endfunction

	function automatic logic [63:0] dl_at(int p);
		return tbl_deadline[heap_slot[p]];
	endfunction

	function automatic void swap_at(int i, int j);
		int t;
		t = heap_slot[i];
		heap_slot[i] = heap_slot[j];
		heap_slot[j] = t;
		tbl_pos[heap_slot[i]] = i;
		tbl_pos[heap_slot[j]] = j;
	endfunction

	function automatic void walk_up(int i);
		int p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!is_later(dl_at(p), dl_at(i))) break;
			swap_at(p, i);
			i = p;
		end
	endfunction

	function automatic void walk_down(int i);
		int l, r, s;
		while (2 * i + 1 < heap_n) begin
			l = 2 * i + 1;
			r = 2 * i + 2;
			s = i;
			if (is_later(dl_at(s), dl_at(l))) s = l;
			if (r < heap_n && is_later(dl_at(s), dl_at(r))) s = r;
			if (s == i) break;
			swap_at(i, s);
			i = s;
		end
	endfunction

	function automatic void heap_add(int s);
		if (heap_n >= NT) return;
		heap_slot[heap_n] = s;
		tbl_pos[s] = heap_n;
		tbl_sched[s] = 1'b1;
		heap_n++;
		walk_up(heap_n - 1);
	endfunction

	function automatic void heap_take_top();
		if (heap_n == 0) return;
		tbl_sched[heap_slot[0]] = 1'b0;
		heap_n--;
		if (heap_n > 0) begin
			heap_slot[0] = heap_slot[heap_n];
			tbl_pos[heap_slot[0]] = 0;
			walk_down(0);
		end
	endfunction

	function automatic void heap_drop(int s);
		int idx;
		if (!tbl_sched[s]) return;
		idx = tbl_pos[s];
		tbl_sched[s] = 1'b0;
		heap_n--;
		if (heap_n > 0 && idx < heap_n) begin
			heap_slot[idx] = heap_slot[heap_n];
			tbl_pos[heap_slot[idx]] = idx;
			if (idx > 0 && is_later(dl_at((idx - 1) / 2), dl_at(idx))) walk_up(idx);
			else walk_down(idx);
		end
	endfunction

	function automatic int slot_of(logic [15:0] h);
		for (int i = 0; i < NT; i++)
			if (tbl_handle[i] == h) return i;
		return -1;
	endfunction

	function automatic logic [63:0] earliest();
		return heap_n > 0 ? dl_at(0) : 64'd0;
	endfunction

	// one expected word; rearm_deadline follows the earliest deadline unless rearmed
	function automatic void push_word(logic [1:0] st, logic f, logic [15:0] fh,
			logic [31:0] fg, logic ra, logic [63:0] rd, logic [31:0] g, logic lst);
		result_t w;
		w.status = st;
		w.fired = f;
		w.fired_handle = fh;
		w.fired_generation = fg;
		w.rearm = ra;
		w.rearm_deadline = ra ? rd : earliest();
		w.generation = g;
		w.active_count = heap_n[3:0];
		w.last = lst;
		expected_words.push_back(w);
	endfunction

	function automatic void timer_predict(item_t it);
		int s, n, slot;
		logic [15:0] fh [MAX_RES];
		logic [31:0] fg [MAX_RES];
		logic [63:0] p, nxt, behind;
		logic [31:0] g;
		case (it.kind)
			KIND_INIT: begin
				for (int i = 0; i < NT; i++) begin
					tbl_handle[i] = 16'd0;
					tbl_sched[i] = 1'b0;
				end
				heap_n = 0;
				gen_counter = 32'd1;
				is_running = 1'b1;
				push_word(ST_OK, 0, 0, 0, 0, 0, 0, 1);
				return;
			end
			KIND_SHUTDOWN: begin
				is_running = 1'b0;
				push_word(ST_OK, 0, 0, 0, 1, 0, 0, 1);
				return;
			end
			KIND_QUERY: begin
				if (it.task_handle == 16'd0) begin
					push_word(ST_PARAM_ERR, 0, 0, 0, 0, 0, 0, 1);
					return;
				end
				s = slot_of(it.task_handle);
				g = (s >= 0) ? tbl_gen[s] : 32'd0;
				push_word(ST_OK, 0, 0, 0, 0, 0, g, 1);
				return;
			end
			KIND_EXPIRE: begin
				n = 0;
				while (heap_n > 0 && n < MAX_RES) begin
					slot = heap_slot[0];
					if (is_later(tbl_deadline[slot], it.now_us)) break;
					heap_take_top();
					fh[n] = tbl_handle[slot];
					fg[n] = tbl_gen[slot];
					n++;
					if (tbl_period[slot] != 32'd0) begin
						p = {32'd0, tbl_period[slot]};
						nxt = tbl_deadline[slot] + p;
						behind = it.now_us - nxt;
						// catch-up when more than four periods behind, product at full width
						if (!behind[63] && behind > (p << 2)) nxt = it.now_us + p;
						tbl_deadline[slot] = nxt;
						tbl_gen[slot]++;
						heap_add(slot);
					end
				end
				if (n == 0) push_word(ST_OK, 0, 0, 0, 1, earliest(), 0, 1);
				for (int k = 0; k < n; k++)
					push_word(ST_OK, 1, fh[k], fg[k], 1, earliest(), 0, k == n - 1);
				return;
			end
			default: ;
		endcase
		if (!is_running) begin
			push_word(ST_NOT_ACTIVE, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		if (it.task_handle == 16'd0) begin
			push_word(ST_PARAM_ERR, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		if (it.kind == KIND_INSERT) begin
			s = slot_of(16'd0);
			if (s < 0) begin
				push_word(ST_FULL, 0, 0, 0, 0, 0, 0, 1);
				return;
			end
			tbl_handle[s] = it.task_handle;
			tbl_deadline[s] = 64'd0;
			tbl_period[s] = 32'd0;
			tbl_gen[s] = gen_counter;
			gen_counter++;
			tbl_sched[s] = 1'b0;
			push_word(ST_OK, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		s = slot_of(it.task_handle);
		if (it.kind == KIND_REMOVE) begin
			if (s < 0) begin
				push_word(ST_NOT_ACTIVE, 0, 0, 0, 0, 0, 0, 1);
				return;
			end
			g = {31'd0, tbl_sched[s]};
			if (tbl_sched[s]) heap_drop(s);
			tbl_handle[s] = 16'd0;
			tbl_gen[s]++;
			push_word(ST_OK, 0, 0, 0, g[0], earliest(), 0, 1);
			return;
		end
		if (it.kind == KIND_PRIME) begin
			if (s < 0) begin
				push_word(ST_NOT_ACTIVE, 0, 0, 0, 0, 0, 0, 1);
				return;
			end
			heap_drop(s);
			tbl_deadline[s] = it.now_us + {32'd0, it.delay_us};
			tbl_period[s] = it.periodic ? it.delay_us : 32'd0;
			tbl_gen[s]++;
			heap_add(s);
			push_word(ST_OK, 0, 0, 0, 1, earliest(), 0, 1);
			return;
		end
		// cancel
		if (s < 0 || !tbl_sched[s]) begin
			push_word(ST_NOT_ACTIVE, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		heap_drop(s);
		tbl_gen[s]++;
		push_word(ST_OK, 0, 0, 0, 1, earliest(), 0, 1);
	endfunction

	// driver: bursts with random gaps, predicts each word as it is accepted
	int burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (req.valid && req.ready) timer_predict(req.data);
			if (!req.valid || req.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req.valid <= 1'b0;
				end else if (pending_words.size() > 0 && !drain_hold) begin
					if (burst_left == 0) begin
						burst_left = $urandom_range(12, 1);
						gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
					end
					burst_left--;
					req.valid <= 1'b1;
					req.data <= pending_words.pop_front();
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern: long ready stretches, then random stalls
	int stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_phase = 0;
		end else begin
			stall_phase = (stall_phase + 1) % 160;
			if (stall_phase < 50) rsp.ready <= 1'b1;
			else rsp.ready <= ($urandom_range(3, 0) != 0);
		end
	end

	// monitor: compare each accepted word with the oldest expectation
	int idle_cycles;
	always @(posedge clk) begin
		result_t w, e;
		if (arst_n && rsp.valid && rsp.ready) begin
			w = rsp.data;
			if (expected_words.size() == 0) begin
				$error("unexpected result word %p", w);
				fail_count++;
			end else begin
				e = expected_words.pop_front();
				if (w.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, w.status); fail_count++;
				end
				if (w.fired !== e.fired) begin
					$error("fired exp %0d got %0d", e.fired, w.fired); fail_count++;
				end
				if (w.fired_handle !== e.fired_handle) begin
					$error("fired_handle exp %h got %h", e.fired_handle, w.fired_handle);
					fail_count++;
				end
				if (w.fired_generation !== e.fired_generation) begin
					$error("fired_generation exp %h got %h", e.fired_generation,
						w.fired_generation);
					fail_count++;
				end
				if (w.rearm !== e.rearm) begin
					$error("rearm exp %0d got %0d", e.rearm, w.rearm); fail_count++;
				end
				if (w.rearm_deadline !== e.rearm_deadline) begin
					$error("rearm_deadline exp %h got %h", e.rearm_deadline, w.rearm_deadline);
					fail_count++;
				end
				if (w.generation !== e.generation) begin
					$error("generation exp %h got %h", e.generation, w.generation);
					fail_count++;
				end
				if (w.active_count !== e.active_count) begin
					$error("active_count exp %0d got %0d", e.active_count, w.active_count);
					fail_count++;
				end
				if (w.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, w.last); fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	logic [15:0] handle_pool [6] = '{16'h0001, 16'h0002, 16'hFFFF, 16'h8000, 16'h1234, 16'h0007};
	logic [63:0] clock_us;

	function automatic item_t mk(logic [2:0] k, logic [15:0] h, logic [31:0] d,
			logic per, logic [63:0] now);
		item_t it;
		it.kind = k;
		it.task_handle = h;
		it.delay_us = d;
		it.periodic = per;
		it.now_us = now;
		return it;
	endfunction

	function automatic logic [31:0] rand_delay();
		case ($urandom_range(5, 0))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return {$urandom_range(1, 0) ? 32'h8000_0000 : 32'h4000_0000} | $urandom;
			default: return $urandom_range(400, 1);
		endcase
	endfunction

	initial begin
		item_t it;
		int kpick;
		fail_count = 0;
		drain_hold = 1'b0;
		idle_cycles = 0;
		clk = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		for (int i = 0; i < NT; i++) begin
			tbl_handle[i] = 0; tbl_deadline[i] = 0; tbl_period[i] = 0;
			tbl_gen[i] = 0; tbl_sched[i] = 0; tbl_pos[i] = 0; heap_slot[i] = 0;
		end
		heap_n = 0;
		gen_counter = 32'd1;
		is_running = 1'b0;

		// directed: not running, null handle, full table, deadline wrap, catch-up
		pending_words.push_back(mk(KIND_INSERT, 16'h0001, 0, 0, 0));
		pending_words.push_back(mk(KIND_EXPIRE, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
		pending_words.push_back(mk(KIND_QUERY, 16'h0000, 0, 0, 0));
		pending_words.push_back(mk(KIND_INIT, 0, 0, 0, 0));
		pending_words.push_back(mk(KIND_INSERT, 16'h0000, 0, 0, 0));
		for (int i = 0; i < 9; i++)
			pending_words.push_back(mk(KIND_INSERT, (i == 8) ? 16'hFFFF : 16'(i + 1), 0, 0, 0));
		pending_words.push_back(mk(KIND_PRIME, 16'h0001, 32'hFFFF_FFFF, 1,
			64'hFFFF_FFFF_FFFF_FFF0));
		pending_words.push_back(mk(KIND_PRIME, 16'h0002, 32'd10, 1, 64'd0));
		pending_words.push_back(mk(KIND_PRIME, 16'h0003, 32'd0, 0, 64'd5));
		pending_words.push_back(mk(KIND_EXPIRE, 0, 0, 0, 64'd1000));
		pending_words.push_back(mk(KIND_CANCEL, 16'h0002, 0, 0, 0));
		pending_words.push_back(mk(KIND_CANCEL, 16'h0002, 0, 0, 0));
		pending_words.push_back(mk(KIND_QUERY, 16'h0001, 0, 0, 0));
		pending_words.push_back(mk(KIND_QUERY, 16'h9999, 0, 0, 0));
		pending_words.push_back(mk(KIND_REMOVE, 16'h0001, 0, 0, 0));
		pending_words.push_back(mk(KIND_REMOVE, 16'h9999, 0, 0, 0));
		pending_words.push_back(mk(KIND_PRIME, 16'h9999, 5, 0, 0));
		pending_words.push_back(mk(KIND_SHUTDOWN, 0, 0, 0, 0));
		pending_words.push_back(mk(KIND_CANCEL, 16'h0003, 0, 0, 0));
		pending_words.push_back(mk(KIND_EXPIRE, 0, 0, 0, 64'd2000));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// random part: mostly running sessions with a small handle pool
		clock_us = 64'(($urandom_range(1, 0)) ? 64'hFFFF_FFFF_FFFF_FF00 : 64'd0);
		for (int n = 0; n < 400; n++) begin
			kpick = $urandom_range(99, 0);
			it.task_handle = ($urandom_range(15, 0) == 0) ? 16'(0) :
				($urandom_range(9, 0) == 0) ? 16'($urandom) : handle_pool[$urandom_range(5, 0)];
			it.delay_us = rand_delay();
			it.periodic = $urandom_range(1, 0);
			if ($urandom_range(7, 0) == 0) clock_us = {$urandom, $urandom};
			else clock_us += $urandom_range(300, 0);
			it.now_us = clock_us;
			if (kpick < 3) it.kind = KIND_INIT;
			else if (kpick < 5) it.kind = KIND_SHUTDOWN;
			else if (kpick < 25) it.kind = KIND_INSERT;
			else if (kpick < 33) it.kind = KIND_REMOVE;
			else if (kpick < 58) it.kind = KIND_PRIME;
			else if (kpick < 66) it.kind = KIND_CANCEL;
			else if (kpick < 92) it.kind = KIND_EXPIRE;
			else it.kind = KIND_QUERY;
			pending_words.push_back(it);
			if (n == 200) begin
				// wait out all traffic once before continuing
				wait (pending_words.size() == 0);
				drain_hold = 1'b1;
				@(posedge clk);
				wait (expected_words.size() == 0 && !req.valid);
				drain_hold = 1'b0;
			end
		end

		wait (pending_words.size() == 0);
		@(posedge clk);
		wait (!req.valid && expected_words.size() == 0);
		repeat (400) @(posedge clk);
		if (fail_count == 0 && expected_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/dtq_pkg.sv
rtl/core/dtq_if.sv
rtl/core/dtq_ctrl.sv
rtl/core/dtq_dp.sv
rtl/core/deadline_timer_queue_top.sv
dv/deadline_timer_queue_top_test.sv
